[hdl/pes_pkg.sv]
// Shared types and constants for the packed element store.
`default_nettype none
package pes_pkg;

  localparam int WORD_W  = 64;
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int POS_W   = 16;
  localparam int OFF_W   = 6;
  localparam int WIDTH_W = 7;
  localparam int COUNT_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 1'b1;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 7'd64;

  typedef struct packed {
    logic load_item;
    logic load_pos;
    logic exec;
    logic clr_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic clr_last;
    logic out_full;
  } ctrl_status_t;

endpackage
`default_nettype wire

[hdl/pes_ifs.sv]
// Command and result channel interfaces of the packed element store.
`default_nettype none
interface pes_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [pes_pkg::CMD_W-1:0]    command;
  logic [pes_pkg::IDX_W-1:0]    element_index;
  logic [pes_pkg::WORD_W-1:0]   element_value;

  modport source(output valid, command, element_index, element_value, input ready);
  modport sink(input valid, command, element_index, element_value, output ready);
endinterface

interface pes_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pes_pkg::WORD_W-1:0]   read_value;
  logic                         status;
  logic                         is_ambiguous;

  modport source(output valid, read_value, status, is_ambiguous, input ready);
  modport sink(input valid, read_value, status, is_ambiguous, output ready);
endinterface
`default_nettype wire

[hdl/pes_bank.sv]
// Single-port word bank with registered read data.
`default_nettype none
module pes_bank #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic                       clk,
  input  wire logic [AW-1:0]              addr,
  input  wire logic                       we,
  input  wire logic [pes_pkg::WORD_W-1:0] wdata,
  output logic      [pes_pkg::WORD_W-1:0] rdata
);

  logic [pes_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[hdl/pes_ctrl.sv]
// Sequencing state machine of the packed element store.
`default_nettype none
module pes_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire pes_pkg::ctrl_status_t status_in,
  output pes_pkg::ctrl_cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_POS    = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_EXEC   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;

  logic [2:0] state, state_next;
  logic       report, report_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      report <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
    end
  end

  always_comb begin
    cmd         = '0;
    state_next  = state;
    report_next = report;
    in_ready    = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (status_in.in_clear) begin
            state_next  = ST_CLEAR;
            report_next = 1'b1;
          end else begin
            state_next = ST_POS;
          end
        end
      end
      ST_POS: begin
        cmd.load_pos = 1'b1;
        state_next   = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_in.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status_in.clr_last) begin
          state_next  = report ? ST_FINISH : ST_IDLE;
          report_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/pes_datapath.sv]
// Datapath: configuration, address math, even/odd word banks, element extract and merge.
`default_nettype none
module pes_datapath #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pes_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [pes_pkg::CMD_W-1:0]      in_command,
  input  wire logic [pes_pkg::IDX_W-1:0]      in_element_index,
  input  wire logic [pes_pkg::WORD_W-1:0]     in_element_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [pes_pkg::WORD_W-1:0]     out_read_value,
  output logic                                out_status,
  output logic                                out_is_ambiguous,
  input  wire pes_pkg::ctrl_cmd_t             cmd,
  output pes_pkg::ctrl_status_t               status_out
);

  localparam int BANK_DEPTH = (MAX_ELEMENTS + 1) / 2;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [BAW-1:0] CLR_LAST_ADDR = BAW'(BANK_DEPTH - 1);

  // configuration
  logic [pes_pkg::WIDTH_W-1:0] alphabet_size;
  logic [pes_pkg::COUNT_W-1:0] element_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= 7'd5;
      element_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pes_pkg::CFG_ALPHABET_SIZE: alphabet_size <= cfg_data[pes_pkg::WIDTH_W-1:0];
        pes_pkg::CFG_ELEMENT_COUNT: element_count <= cfg_data[pes_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // transaction registers
  logic [pes_pkg::CMD_W-1:0]   cmd_reg;
  logic [pes_pkg::IDX_W-1:0]   idx_reg;
  logic [pes_pkg::WORD_W-1:0]  val_reg;
  logic [pes_pkg::WIDTH_W-1:0] w_reg;
  logic                        in_range;
  logic [pes_pkg::POS_W-1:0]   pos_reg;
  logic [pes_pkg::WORD_W-1:0]  rv_reg;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_reg  <= in_command;
      idx_reg  <= in_element_index;
      val_reg  <= in_element_value;
      w_reg    <= (alphabet_size > pes_pkg::WIDTH_MAX) ? pes_pkg::WIDTH_MAX : alphabet_size;
      in_range <= ({1'b0, in_element_index} < element_count) &&
                  (in_element_index < MAX_ELEMENTS);
    end
    if (cmd.load_pos) begin
      pos_reg <= {{(pes_pkg::POS_W-pes_pkg::IDX_W){1'b0}}, idx_reg} *
                 {{(pes_pkg::POS_W-pes_pkg::WIDTH_W){1'b0}}, w_reg};
    end
  end

  // word addressing
  logic [pes_pkg::IDX_W-1:0] word;
  logic [pes_pkg::OFF_W-1:0] off;
  logic                      odd;
  logic [pes_pkg::IDX_W:0]   word_hi;
  logic [pes_pkg::IDX_W:0]   even_word_addr;
  logic [pes_pkg::IDX_W-1:0] odd_word_addr;
  logic                      lo_ok, hi_ok;

  assign word           = pos_reg[pes_pkg::POS_W-1:pes_pkg::OFF_W];
  assign off            = pos_reg[pes_pkg::OFF_W-1:0];
  assign odd            = word[0];
  assign word_hi        = {1'b0, word} + 11'd1;
  assign even_word_addr = word_hi >> 1;
  assign odd_word_addr  = word >> 1;
  assign lo_ok          = ({1'b0, word} < MAX_ELEMENTS);
  assign hi_ok          = (word_hi < MAX_ELEMENTS);

  // clear sweep
  logic [BAW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= (clr_addr == CLR_LAST_ADDR) ? '0 : clr_addr + 1'b1;
    end
  end

  // banks
  logic [BAW-1:0]             even_addr, odd_addr;
  logic                       even_we, odd_we;
  logic [pes_pkg::WORD_W-1:0] even_wdata, odd_wdata;
  logic [pes_pkg::WORD_W-1:0] even_rdata, odd_rdata;

  pes_bank #(.DEPTH(BANK_DEPTH), .AW(BAW)) u_even (
    .clk   (clk),
    .addr  (even_addr),
    .we    (even_we),
    .wdata (even_wdata),
    .rdata (even_rdata)
  );

  pes_bank #(.DEPTH(BANK_DEPTH), .AW(BAW)) u_odd (
    .clk   (clk),
    .addr  (odd_addr),
    .we    (odd_we),
    .wdata (odd_wdata),
    .rdata (odd_rdata)
  );

  // extract and merge
  logic [pes_pkg::WORD_W-1:0]  lo_data, hi_data, lo_eff, hi_eff;
  logic [pes_pkg::WORD_W-1:0]  mask, vm, elem, new_lo, new_hi, hmask;
  logic [pes_pkg::WIDTH_W-1:0] back_sh;
  logic [pes_pkg::WIDTH_W:0]   span;
  logic                        straddle, do_write, we_lo, we_hi;

  always_comb begin
    lo_data  = odd ? odd_rdata : even_rdata;
    hi_data  = odd ? even_rdata : odd_rdata;
    lo_eff   = lo_ok ? lo_data : '0;
    hi_eff   = hi_ok ? hi_data : '0;
    mask     = (w_reg >= pes_pkg::WIDTH_MAX) ? '1 : ((64'd1 << w_reg) - 64'd1);
    span     = {2'b00, off} + {1'b0, w_reg};
    straddle = (off != '0) && (span > 8'd64);
    back_sh  = pes_pkg::WIDTH_MAX - {1'b0, off};
    elem     = ((lo_eff >> off) | (straddle ? (hi_eff << back_sh) : '0)) & mask;
    vm       = val_reg & mask;
    hmask    = straddle ? (mask >> back_sh) : '0;
    new_lo   = (lo_data & ~(mask << off)) | (vm << off);
    new_hi   = (hi_data & ~hmask) | (straddle ? (vm >> back_sh) : '0);
    do_write = cmd.exec && (cmd_reg == pes_pkg::CMD_WRITE) && in_range;
    we_lo    = do_write && lo_ok;
    we_hi    = do_write && straddle && hi_ok;

    if (cmd.clr_step) begin
      even_addr  = clr_addr;
      odd_addr   = clr_addr;
      even_we    = 1'b1;
      odd_we     = 1'b1;
      even_wdata = '0;
      odd_wdata  = '0;
    end else begin
      even_addr  = BAW'(even_word_addr);
      odd_addr   = BAW'(odd_word_addr);
      even_we    = odd ? we_hi : we_lo;
      odd_we     = odd ? we_lo : we_hi;
      even_wdata = odd ? new_hi : new_lo;
      odd_wdata  = odd ? new_lo : new_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rv_reg <= elem;
    end
  end

  // result register
  logic is_read, is_access;

  assign is_read   = (cmd_reg == pes_pkg::CMD_READ);
  assign is_access = is_read || (cmd_reg == pes_pkg::CMD_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_value   <= (is_read && in_range) ? rv_reg : '0;
      out_status       <= is_access && !in_range;
      out_is_ambiguous <= is_read && in_range && ($countones(rv_reg) != 1);
    end
  end

  assign status_out.in_clear = (in_command == pes_pkg::CMD_CLEAR);
  assign status_out.clr_last = (clr_addr == CLR_LAST_ADDR);
  assign status_out.out_full = out_valid && !out_ready;

endmodule
`default_nettype wire

[hdl/packed_element_store.sv]
// Top level of the packed element store.
// Elements of alphabet_size bits (max 64) are packed end to end in 64-bit words held in an
// even and an odd word bank, so an element that straddles two words is read or written in
// one bank access. A read or write passes through capture, index times width multiply, bank
// read, extract/merge and write-back, and result load before the next command is accepted.
// A clear command sweeps both banks one address per cycle over all (MAX_ELEMENTS+1)/2
// addresses, then returns its result. After reset the same sweep runs before the first
// command is taken; configuration writes are taken at any time the block is idle. The
// result register lets a new command enter while the previous result waits.
`default_nettype none
module packed_element_store #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  pes_cmd_if.sink                             cmd_ch,
  pes_rsp_if.source                           rsp_ch,
  input  wire logic                           cfg_we,
  input  wire logic [pes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pes_pkg::CFG_DATA_W-1:0] cfg_data
);

  pes_pkg::ctrl_cmd_t    cmd;
  pes_pkg::ctrl_status_t status;
  logic                  in_ready;

  assign cmd_ch.ready = in_ready;

  pes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_ch.valid),
    .in_ready  (in_ready),
    .status_in (status),
    .cmd       (cmd)
  );

  pes_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (cmd_ch.command),
    .in_element_index (cmd_ch.element_index),
    .in_element_value (cmd_ch.element_value),
    .out_valid        (rsp_ch.valid),
    .out_ready        (rsp_ch.ready),
    .out_read_value   (rsp_ch.read_value),
    .out_status       (rsp_ch.status),
    .out_is_ambiguous (rsp_ch.is_ambiguous),
    .cmd              (cmd),
    .status_out       (status)
  );

endmodule
`default_nettype wire
